FILE: design/ilsi_pkg.sv
package ilsi_pkg;

    // Table geometry
    localparam int NUM_ENTRIES_DEF = 16;
    localparam int NUM_ENTRIES_MAX = 32;
    localparam int IDX_W           = 5;   // holds any entry number up to NUM_ENTRIES_MAX-1

    // Field widths
    localparam int OP_W     = 3;
    localparam int INTID_W  = 13;
    localparam int EIDX_W   = 4;
    localparam int WORD_W   = 64;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int ACTIVE_W = 5;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LENIENT = 3'd0;
    localparam logic [OP_W-1:0] OP_HW      = 3'd1;
    localparam logic [OP_W-1:0] OP_STRICT  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_INJECTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ACCESS   = 2'd3;

    // Entry layout constants
    localparam logic [7:0] VIRT_PRIO = 8'hA0;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INTID_W-1:0] intid;
        logic [EIDX_W-1:0]  entry_index;
        logic [WORD_W-1:0]  entry_value;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [WORD_W-1:0]   read_data;
    } t_out;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic [OP_W-1:0]    op;
        logic [INTID_W-1:0] intid;
        logic [IDX_W-1:0]   rd_idx;
        logic               dup_found;
        logic [IDX_W-1:0]   dup_idx;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
        logic [WORD_W-1:0]  rdata;
    } t_tok;

    // Entry write command broadcast to the row
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] data;
    } t_wr;

    function automatic logic is_inject(input logic [OP_W-1:0] op);
        return (op == OP_LENIENT) || (op == OP_HW) || (op == OP_STRICT);
    endfunction

    // Pending, group 1, priority 0xA0, virtual number in 31:0
    function automatic logic [WORD_W-1:0] build_virtual(input logic [INTID_W-1:0] intid);
        return {2'b01, 1'b0, 1'b1, 4'b0, VIRT_PRIO, 16'b0, 19'b0, intid};
    endfunction

    // Pending, HW, group 1, priority 0, physical number in 44:32
    function automatic logic [WORD_W-1:0] build_hw(input logic [INTID_W-1:0] intid);
        return {2'b01, 1'b1, 1'b1, 4'b0, 8'b0, 3'b0, intid, 19'b0, intid};
    endfunction

endpackage

FILE: design/ilsi_cell.sv
module ilsi_cell
    import ilsi_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [ACTIVE_W-1:0] i_active,
    input  t_tok                i_tok,
    input  t_wr                 i_wr,
    output t_tok                o_tok
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [WORD_W-1:0] r_entry;
    t_tok              r_tok;
    t_tok              n_tok;
    logic              in_scan;
    logic              ent_valid;
    logic              ent_holds;
    logic              lenient;

    assign in_scan   = (MY_IDX < i_active);
    assign ent_valid = (r_entry[63:62] != 2'b00);
    assign ent_holds = (r_entry[31:0] == {19'b0, i_tok.intid});
    assign lenient   = (i_tok.op == OP_LENIENT);

    // Stored entry: written by the addressed broadcast command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_wr.en && (i_wr.idx == MY_IDX)) begin
            r_entry <= i_wr.data;
        end
    end

    // Token update as it passes this entry
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && is_inject(i_tok.op) && in_scan) begin
            if (lenient) begin
                // first event along the row decides
                if (!i_tok.dup_found && !i_tok.free_found) begin
                    if (!ent_valid) begin
                        n_tok.free_found = 1'b1;
                        n_tok.free_idx   = MY_IDX;
                    end else if (ent_holds) begin
                        n_tok.dup_found = 1'b1;
                        n_tok.dup_idx   = MY_IDX;
                    end
                end
            end else begin
                if (ent_valid && ent_holds && !i_tok.dup_found) begin
                    n_tok.dup_found = 1'b1;
                    n_tok.dup_idx   = MY_IDX;
                end
                if (!ent_valid && !i_tok.free_found) begin
                    n_tok.free_found = 1'b1;
                    n_tok.free_idx   = MY_IDX;
                end
            end
        end
        if (i_tok.valid && (i_tok.op == OP_READ) && (i_tok.rd_idx == MY_IDX)) begin
            n_tok.rdata = r_entry;
        end
    end

    // Hand the token to the next cell; only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.op         <= n_tok.op;
        r_tok.intid      <= n_tok.intid;
        r_tok.rd_idx     <= n_tok.rd_idx;
        r_tok.dup_found  <= n_tok.dup_found;
        r_tok.dup_idx    <= n_tok.dup_idx;
        r_tok.free_found <= n_tok.free_found;
        r_tok.free_idx   <= n_tok.free_idx;
        r_tok.rdata      <= n_tok.rdata;
    end

    assign o_tok = r_tok;

endmodule

FILE: design/interrupt_list_slot_injector_unit.sv
// Interrupt list slot injector.
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one request per
// transaction: a lenient, strict or hardware-linked inject of an interrupt
// number, or a direct write or read of one list entry. Each request gives
// exactly one result on the output channel (o_out_valid / i_out_stall /
// o_out_data): status, slot and read data.
// The entries sit in a row of NUM_ENTRIES cells. A scan token enters cell 0
// and moves one cell per cycle, collecting the first free entry, the first
// duplicate (for a lenient inject, only whichever of the two comes first)
// and any read data. When it leaves the last cell the controller decides,
// writes the chosen entry and loads the result holding register, which moves
// to the output register once that is free. One request is in flight at a
// time: the input stalls from acceptance until the result has moved there.
// A finished result waits in the output register while the receiver stalls;
// the next request is accepted meanwhile, and its result is held back until
// the output register is free.
// The configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) sets
// the number of entries scanned by injects; the user must write it only when
// idle, not enforced by the block. Reset (synchronous, active low) clears every
// entry to free, sets the scanned count to 16 and empties the output register.
module interrupt_list_slot_injector_unit
    import ilsi_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in                 i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out                o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [ACTIVE_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [ACTIVE_W-1:0] r_active;
    t_tok              tok [NUM_ENTRIES+1];
    t_tok              tok_in;
    t_tok              exit_tok;
    t_wr               wr;
    t_out              r_res;
    t_out              n_res;
    logic              r_out_valid;
    t_out              r_out;
    logic              in_acc;
    logic              out_free;
    logic [IDX_W-1:0]  ei_idx;
    logic              ei_ok;
    logic [31:0]       slot_wide;
    logic [WORD_W-1:0] inj_word;
    // Write data of an entry write waits here while the token travels
    logic [WORD_W-1:0] r_res_value;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Scanned entry count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active <= i_cfg_data;
        end
    end

    // Fresh token into the first cell
    always_comb begin
        tok_in            = '0;
        tok_in.valid      = in_acc;
        tok_in.op         = i_in_data.op;
        tok_in.intid      = i_in_data.intid;
        tok_in.rd_idx     = IDX_W'(i_in_data.entry_index);
    end

    assign tok[0] = tok_in;

    // Row of entry cells
    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
        ilsi_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_active (r_active),
            .i_tok    (tok[g]),
            .i_wr     (wr),
            .o_tok    (tok[g+1])
        );
    end

    assign exit_tok = tok[NUM_ENTRIES];

    // Final decision on the token leaving the row
    assign ei_idx   = IDX_W'(exit_tok.rd_idx);
    assign ei_ok    = ({27'b0, exit_tok.rd_idx} < 32'(NUM_ENTRIES));
    assign inj_word = (exit_tok.op == OP_HW) ? build_hw(exit_tok.intid)
                                             : build_virtual(exit_tok.intid);

    always_comb begin
        wr        = '0;
        n_res     = '0;
        slot_wide = '0;
        n_res.status = ST_ACCESS;
        if (is_inject(exit_tok.op)) begin
            if (exit_tok.dup_found) begin
                n_res.status = ST_PRESENT;
                slot_wide    = 32'(exit_tok.dup_idx);
            end else if (exit_tok.free_found) begin
                n_res.status = ST_INJECTED;
                slot_wide    = 32'(exit_tok.free_idx);
                wr.en        = exit_tok.valid && (r_state == S_SCAN);
                wr.idx       = exit_tok.free_idx;
                wr.data      = inj_word;
            end else begin
                n_res.status = ST_FULL;
            end
        end else if (exit_tok.op == OP_WRITE) begin
            slot_wide = 32'(exit_tok.rd_idx);
            wr.en     = exit_tok.valid && (r_state == S_SCAN) && ei_ok;
            wr.idx    = ei_idx;
            wr.data   = r_res_value;
        end else if (exit_tok.op == OP_READ) begin
            slot_wide       = 32'(exit_tok.rd_idx);
            n_res.read_data = exit_tok.rdata;
        end
        n_res.slot = slot_wide[SLOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res_value <= i_in_data.entry_value;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (exit_tok.valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Result holding register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && exit_tok.valid) begin
            r_res <= n_res;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/ilsi_chk.sv
module ilsi_chk
    import ilsi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  t_out                o_out_data
);

    // Stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result dropped or changed");

    // One request in flight: the input stalls right after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in flight");

    // No free entry reports slot zero
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_FULL) |-> (o_out_data.slot == '0))
        else $error("full status with nonzero slot");

    // Read data only comes with an access result
    a_rdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_ACCESS) |-> (o_out_data.read_data == '0))
        else $error("inject result carries read data");

endmodule

bind interrupt_list_slot_injector_unit ilsi_chk u_ilsi_chk (.*);

FILE: verif/tb_interrupt_list_slot_injector_unit.sv
`timescale 1ns / 100ps

module tb_interrupt_list_slot_injector_unit;
    import ilsi_pkg::*;

    localparam int N_SLOTS     = 16;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 225;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF    = 200;
    localparam int DRAIN_WAIT  = 40;
    localparam int MAX_REPORTS = 10;

    // opcodes the block does not decode
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // one line of the directed table
    typedef struct packed {
        logic                has_cfg;
        logic [ACTIVE_W-1:0] cfg;
        t_in                 req;
        logic                has_exp;
        t_out                exp;
    } t_dir_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in                 i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out                o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [ACTIVE_W-1:0] i_cfg_data  = '0;

    // shadow copy of the list and the scanned count
    logic [WORD_W-1:0]   shadow_list [N_SLOTS];
    logic [ACTIVE_W-1:0] shadow_active;

    t_out     pending_results [$];
    t_dir_row dir_rows [$];
    t_out     want_result;
    int       errors    = 0;
    int       cycles    = 0;
    int       hold_left = 0;
    logic     quiet     = 1'b0;

    interrupt_list_slot_injector_unit #(
        .NUM_ENTRIES(N_SLOTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Works out the result of one request and updates the shadow list
    function automatic t_out predict_slot_result(input t_in req);
        t_out              res;
        int                n;
        int                dup;
        int                free_at;
        logic [WORD_W-1:0] word;
        res        = '0;
        res.status = ST_ACCESS;
        n          = (shadow_active > N_SLOTS) ? N_SLOTS : int'(shadow_active);
        dup        = -1;
        free_at    = -1;
        // entry word as an inject would build it
        word              = '0;
        word[62]          = 1'b1;
        word[60]          = 1'b1;
        word[INTID_W-1:0] = req.intid;
        if (req.op == OP_HW) begin
            word[61]    = 1'b1;
            word[44:32] = req.intid;
        end else begin
            word[55:48] = 8'hA0;
        end
        case (req.op)
            OP_LENIENT: begin
                // stops at the first free entry or the first holder, whichever comes first
                for (int i = 0; i < n; i++) begin
                    if (free_at < 0 && dup < 0) begin
                        if (shadow_list[i][63:62] == 2'b00)
                            free_at = i;
                        else if (shadow_list[i][31:0] == {19'b0, req.intid})
                            dup = i;
                    end
                end
            end
            OP_HW, OP_STRICT: begin
                for (int i = 0; i < n; i++) begin
                    if (dup < 0 && shadow_list[i][63:62] != 2'b00
                            && shadow_list[i][31:0] == {19'b0, req.intid})
                        dup = i;
                    if (free_at < 0 && shadow_list[i][63:62] == 2'b00)
                        free_at = i;
                end
                if (dup >= 0)
                    free_at = -1;
            end
            OP_WRITE: begin
                res.slot = req.entry_index;
                shadow_list[req.entry_index] = req.entry_value;
            end
            OP_READ: begin
                res.slot      = req.entry_index;
                res.read_data = shadow_list[req.entry_index];
            end
            default: ;
        endcase
        if (req.op == OP_LENIENT || req.op == OP_HW || req.op == OP_STRICT) begin
            if (free_at >= 0) begin
                shadow_list[free_at] = word;
                res.status = ST_INJECTED;
                res.slot   = SLOT_W'(free_at);
            end else if (dup >= 0) begin
                res.status = ST_PRESENT;
                res.slot   = SLOT_W'(dup);
            end else begin
                res.status = ST_FULL;
            end
        end
        return res;
    endfunction

    // Random request: small number pool for duplicates, frequent retires
    function automatic t_in random_request();
        t_in req;
        int  pick;
        pick            = $urandom_range(0, 99);
        req.entry_index = EIDX_W'($urandom_range(0, 15));
        req.entry_value = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
            req.intid = INTID_W'($urandom_range(0, 8191));
        else
            req.intid = INTID_W'($urandom_range(0, 11));
        if (pick < 24)
            req.op = OP_LENIENT;
        else if (pick < 38)
            req.op = OP_HW;
        else if (pick < 52)
            req.op = OP_STRICT;
        else if (pick < 78)
            req.op = OP_WRITE;
        else if (pick < 95)
            req.op = OP_READ;
        else
            req.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        if (req.op == OP_WRITE) begin
            case ($urandom_range(0, 5))
                0, 1, 2: req.entry_value = '0;
                3: begin
                    // free entry still holding a number
                    req.entry_value[63:62] = 2'b00;
                    req.entry_value[31:0]  = 32'($urandom_range(0, 11));
                end
                4: req.entry_value[31:0] = 32'($urandom_range(0, 11));
                default: ;
            endcase
        end
        return req;
    endfunction

    task automatic add_row(input logic has_cfg, input logic [ACTIVE_W-1:0] cfg,
                           input logic [OP_W-1:0] op, input logic [INTID_W-1:0] intid,
                           input logic [EIDX_W-1:0] idx, input logic [WORD_W-1:0] value,
                           input logic has_exp, input logic [STATUS_W-1:0] status,
                           input logic [SLOT_W-1:0] slot);
        t_dir_row row;
        row.has_cfg               = has_cfg;
        row.cfg                   = cfg;
        row.req.op                = op;
        row.req.intid             = intid;
        row.req.entry_index       = idx;
        row.req.entry_value       = value;
        row.has_exp               = has_exp;
        row.exp.status            = status;
        row.exp.slot              = slot;
        row.exp.read_data         = '0;
        dir_rows.push_back(row);
    endtask

    // One input transaction; called and returns at a falling edge
    task automatic send_request(input t_in req, input logic typed, input t_out typed_res);
        t_out res;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = predict_slot_result(req);
        pending_results.push_back(typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_active(input logic [ACTIVE_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_active = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Output side: random stall bursts, one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left   = hold_left - 1;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 5) - 1) @(negedge i_clk);
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                errors = errors + 1;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: status %0d slot %0d data %h",
                             o_out_data.status, o_out_data.slot, o_out_data.read_data);
            end else begin
                want_result = pending_results.pop_front();
                if (o_out_data.status != want_result.status
                        || o_out_data.slot != want_result.slot
                        || o_out_data.read_data != want_result.read_data) begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: status %0d/%0d slot %0d/%0d data %h/%h (exp/act)",
                                 want_result.status, o_out_data.status,
                                 want_result.slot, o_out_data.slot,
                                 want_result.read_data, o_out_data.read_data);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_interrupt_list_slot_injector_unit: errors");
            $finish;
        end
    end

    initial begin
        foreach (shadow_list[k])
            shadow_list[k] = '0;
        shadow_active = ACTIVE_RST;

        // Directed table: reset state, number extremes, lenient blind spot,
        // free entries holding a number, upper bits spoiling a match, spare opcodes,
        // zero and oversized scan counts
        add_row(0, 0, OP_READ,    0,       0,  '0, 1, ST_ACCESS,   0);
        add_row(0, 0, OP_READ,    0,       15, '0, 1, ST_ACCESS,   15);
        add_row(0, 0, OP_LENIENT, 0,       0,  '0, 1, ST_INJECTED, 0);
        add_row(0, 0, OP_LENIENT, 0,       0,  '0, 1, ST_PRESENT,  0);
        add_row(0, 0, OP_STRICT,  13'h1FFF, 0, '0, 0, ST_INJECTED, 0);
        add_row(0, 0, OP_HW,      13'h1FFF, 0, '0, 0, ST_INJECTED, 0);
        add_row(0, 0, OP_HW,      13'h1555, 0, '0, 0, ST_INJECTED, 0);
        add_row(0, 0, OP_READ,    0,       2,  '0, 0, ST_ACCESS,   0);
        add_row(0, 0, OP_READ,    0,       1,  '0, 0, ST_ACCESS,   0);
        add_row(0, 0, OP_WRITE,   0,       0,  '0, 1, ST_ACCESS,   0);
        add_row(0, 0, OP_LENIENT, 13'h1555, 0, '0, 0, ST_INJECTED, 0);
        add_row(0, 0, OP_WRITE,   0,       0,  '0, 1, ST_ACCESS,   0);
        add_row(0, 0, OP_STRICT,  13'h1555, 0, '0, 0, ST_INJECTED, 0);
        add_row(0, 0, OP_WRITE,   0,       3,  '1, 1, ST_ACCESS,   3);
        add_row(0, 0, OP_WRITE,   0,       4,  64'h0000_0000_0000_0AAA, 1, ST_ACCESS, 4);
        add_row(0, 0, OP_STRICT,  13'h0AAA, 0, '0, 0, ST_INJECTED, 0);
        add_row(0, 0, OP_WRITE,   0,       5,  64'h8000_0000_0000_1234, 1, ST_ACCESS, 5);
        add_row(0, 0, OP_HW,      13'h1234, 0, '0, 0, ST_INJECTED, 0);
        add_row(0, 0, OP_WRITE,   0,       6,  64'h4FFF_FFFF_0001_0BCD, 1, ST_ACCESS, 6);
        add_row(0, 0, OP_STRICT,  13'h0BCD, 0, '0, 0, ST_INJECTED, 0);
        add_row(0, 0, OP_SPARE_LO, 13'h1FFF, 15, '1, 1, ST_ACCESS, 0);
        add_row(0, 0, OP_SPARE_HI, 13'h1FFF, 15, '1, 1, ST_ACCESS, 0);
        add_row(1, 0,  OP_LENIENT, 5, 0, '0, 1, ST_FULL, 0);
        add_row(1, 1,  OP_STRICT,  5, 0, '0, 1, ST_FULL, 0);
        add_row(1, 31, OP_HW,      7, 0, '0, 0, ST_INJECTED, 0);

        // synchronous reset, released on a falling edge
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].has_cfg) begin
                drain_results();
                write_active(dir_rows[r].cfg);
            end
            send_request(dir_rows[r].req, dir_rows[r].has_exp, dir_rows[r].exp);
        end

        // Random phases, each under a scan count written at its start
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            case (ph)
                0, 6, 7: write_active(ACTIVE_RST);
                1:       write_active(ACTIVE_W'(1));
                2:       write_active(ACTIVE_W'(31));
                3:       write_active(ACTIVE_W'(0));
                default: write_active(ACTIVE_W'($urandom_range(2, 15)));
            endcase
            if (ph == 1)
                hold_left = HOLD_OFF;
            if (ph == RAND_PHASES - 1)
                quiet = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_request(random_request(), 1'b0, '0);
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("tb_interrupt_list_slot_injector_unit: clean");
        else
            $display("tb_interrupt_list_slot_injector_unit: errors");
        $finish;
    end

endmodule

FILE: sim.f
design/ilsi_pkg.sv
design/ilsi_cell.sv
design/interrupt_list_slot_injector_unit.sv
design/ilsi_chk.sv
verif/tb_interrupt_list_slot_injector_unit.sv
